[src/bpd_pkg.sv]
`default_nettype none
package bpd_pkg;

  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RED_MASK   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GREEN_MASK = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BLUE_MASK  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEPTH      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PAL_COUNT  = 3'd4;

  localparam logic [31:0] RED_MASK_RESET   = 32'h00ff_0000;
  localparam logic [31:0] GREEN_MASK_RESET = 32'h0000_ff00;
  localparam logic [31:0] BLUE_MASK_RESET  = 32'h0000_00ff;
  localparam logic [5:0]  DEPTH_RESET      = 6'd24;
  localparam logic [8:0]  PAL_COUNT_RESET  = 9'd0;

  localparam logic [5:0] DEPTH_MAX_INDEXED = 6'd8;
  localparam logic [5:0] DEPTH_16          = 6'd16;
  localparam logic [5:0] DEPTH_24          = 6'd24;
  localparam logic [5:0] DEPTH_32          = 6'd32;

  // Mask of one channel together with the bit position just above its
  // lowest run of ones; that position decides the alignment shift.
  typedef struct packed {
    logic [31:0] mask;
    logic [5:0]  top;
  } chan_cfg_t;

  typedef struct packed {
    chan_cfg_t red;
    chan_cfg_t green;
    chan_cfg_t blue;
  } color_cfg_t;

  // Adding the lowest set bit to the mask clears the lowest run of ones and
  // carries into the first zero above it. That carry bit is the only bit
  // set in the sum that is clear in the mask, so its index is a plain
  // one-hot encode.
  function automatic logic [5:0] chan_top(input logic [31:0] mask);
    logic [31:0] low_bit;
    logic [32:0] sum;
    logic [32:0] carry_bit;
    logic [5:0]  pos;
    low_bit   = mask & (~mask + 32'd1);
    sum       = {1'b0, mask} + {1'b0, low_bit};
    carry_bit = sum & ~{1'b0, mask};
    pos       = '0;
    for (int i = 0; i < 33; i++) begin
      if (carry_bit[i]) begin
        pos = pos | 6'(i);
      end
    end
    return pos;
  endfunction

endpackage
`default_nettype wire

[src/bpd_ram.sv]
`default_nettype none
module bpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[src/bpd_cfg.sv]
`default_nettype none
module bpd_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              write,
  input  wire logic [bpd_pkg::CFG_INDEX_BITS-1:0] index,
  input  wire logic [31:0]                       data,
  output      bpd_pkg::color_cfg_t               color,
  output      logic [5:0]                        depth,
  output      logic [8:0]                        pal_count
);
  import bpd_pkg::*;

  // The alignment position of each mask is worked out as the mask is
  // written, so the pixel path only has to shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      color.red.mask   <= RED_MASK_RESET;
      color.red.top    <= chan_top(RED_MASK_RESET);
      color.green.mask <= GREEN_MASK_RESET;
      color.green.top  <= chan_top(GREEN_MASK_RESET);
      color.blue.mask  <= BLUE_MASK_RESET;
      color.blue.top   <= chan_top(BLUE_MASK_RESET);
      depth            <= DEPTH_RESET;
      pal_count        <= PAL_COUNT_RESET;
    end else if (write) begin
      case (index)
        REG_RED_MASK: begin
          color.red.mask <= data;
          color.red.top  <= chan_top(data);
        end
        REG_GREEN_MASK: begin
          color.green.mask <= data;
          color.green.top  <= chan_top(data);
        end
        REG_BLUE_MASK: begin
          color.blue.mask <= data;
          color.blue.top  <= chan_top(data);
        end
        REG_DEPTH:     depth     <= data[5:0];
        REG_PAL_COUNT: pal_count <= data[8:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[src/bpd_pack.sv]
`default_nettype none
module bpd_pack (
  input  wire logic [31:0]         word,
  input  wire bpd_pkg::color_cfg_t color,
  output      logic [31:0]         rgb
);
  import bpd_pkg::*;

  // Aligns the top bit of the channel's run of ones with bit 7.
  function automatic logic [31:0] extract(input logic [31:0] w, input chan_cfg_t c);
    logic [31:0] masked;
    logic [31:0] res;
    masked = w & c.mask;
    if (c.top > 6'd8) begin
      res = masked >> (c.top - 6'd8);
    end else begin
      res = masked << (6'd8 - c.top);
    end
    return res;
  endfunction

  logic [31:0] red;
  logic [31:0] green;
  logic [31:0] blue;

  always_comb begin
    red   = extract(word, color.red);
    green = extract(word, color.green);
    blue  = extract(word, color.blue);
    rgb   = (red << 16) | (green << 8) | blue;
  end

endmodule
`default_nettype wire

[src/bitmap_pixel_color_decoder.sv]
`default_nettype none
// Bitmap pixel decoder: takes one word per clock while in_stall is low and returns one
// packed RGB word per pixel decode; palette writes return nothing. Stage one computes the
// palette index or the masked direct color and issues the palette read; the output
// register takes the registered read data of the single-port-per-direction palette RAM and
// holds a result under out_stall while the next word is still taken in. Palette writes go
// to the RAM at acceptance, so a later lookup always sees them. Palette entries hold
// nothing until written. The user must write channel masks, depth and palette count
// through the configuration port while no word is in flight; the block does not check this.
module bitmap_pixel_color_decoder #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int COLUMN_BITS     = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic                              op,
  input  wire logic [COLUMN_BITS-1:0]            x_pos,
  input  wire logic [31:0]                       pixel_word,
  input  wire logic [7:0]                        palette_slot,
  input  wire logic [31:0]                       palette_raw_color,
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic [31:0]                       rgb_word,
  output      logic                              index_error,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [bpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [31:0]                       cfg_data
);
  import bpd_pkg::*;

  localparam int ADDR_BITS = $clog2(PALETTE_ENTRIES);
  localparam logic [8:0] ENTRIES_LIMIT = 9'(PALETTE_ENTRIES);

  typedef struct packed {
    logic        lookup;
    logic        err;
    logic [31:0] rgb;
  } stage_t;

  color_cfg_t color;
  logic [5:0] depth;
  logic [8:0] pal_count;

  logic        in_acc;
  logic        advance;
  logic        depth_small;
  logic [2:0]  bit_pos;
  logic [15:0] window;
  logic [4:0]  shamt;
  logic [15:0] field;
  logic [7:0]  idx_mask;
  logic [7:0]  idx;
  logic [8:0]  limit;
  logic        idx_err;
  logic [31:0] pix;
  logic [31:0] pack_in;
  logic [31:0] pack_out;
  logic        ram_we;
  logic        ram_re;
  logic [31:0] ram_rdata;

  logic   s1_valid;
  stage_t s1;

  assign cfg_ready = 1'b1;

  bpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .write     (cfg_valid && cfg_ready),
    .index     (cfg_index),
    .data      (cfg_data),
    .color     (color),
    .depth     (depth),
    .pal_count (pal_count)
  );

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign in_acc   = in_valid && !in_stall;

  // Sub-byte index: the field starts at bit (x * depth) mod 8, counted from
  // the top of the first byte, and may run on into the second byte.
  always_comb begin
    depth_small = depth <= DEPTH_MAX_INDEXED;
    bit_pos     = 3'(x_pos[2:0] * depth[2:0]);
    window      = {pixel_word[7:0], pixel_word[15:8]};
    shamt       = 5'(5'd16 - {1'b0, depth[3:0]} - {2'b00, bit_pos});
    field       = window >> shamt;
    idx_mask    = 8'((9'd1 << depth[3:0]) - 9'd1);
    idx         = field[7:0] & idx_mask;
    limit       = (pal_count > ENTRIES_LIMIT) ? ENTRIES_LIMIT : pal_count;
    idx_err     = {1'b0, idx} >= limit;
  end

  always_comb begin
    case (depth)
      DEPTH_16: pix = {16'h0000, pixel_word[15:0]};
      default: begin
        if (depth inside {DEPTH_24, DEPTH_32}) begin
          pix = pixel_word;
        end else begin
          pix = '0;
        end
      end
    endcase
  end

  // One channel splitter serves both palette writes and direct color.
  assign pack_in = (op == OP_WRITE) ? palette_raw_color : pix;

  bpd_pack u_pack (
    .word  (pack_in),
    .color (color),
    .rgb   (pack_out)
  );

  assign ram_we = in_acc && (op == OP_WRITE) && ({1'b0, palette_slot} < ENTRIES_LIMIT);
  assign ram_re = in_acc && (op == OP_DECODE) && depth_small && !idx_err;

  bpd_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (palette_slot[ADDR_BITS-1:0]),
    .wdata (pack_out),
    .re    (ram_re),
    .raddr (idx[ADDR_BITS-1:0]),
    .rdata (ram_rdata)
  );

  // An empty stage one takes a word even while the output register is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance || !s1_valid) begin
      s1_valid <= in_acc && (op == OP_DECODE);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1.lookup <= depth_small && !idx_err;
      s1.err    <= depth_small && idx_err;
      s1.rgb    <= pack_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  // The read data stays put while stage one is held, since no new word is
  // taken in and so no new read is issued.
  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      if (s1.lookup) begin
        rgb_word <= ram_rdata;
      end else if (s1.err) begin
        rgb_word <= '0;
      end else begin
        rgb_word <= s1.rgb;
      end
      index_error <= s1.err;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> rgb_word == 32'd0)
    else $error("index error result carries a nonzero color");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    in_acc && (op == OP_WRITE) |=> !s1_valid)
    else $error("palette write produced a result");

  a_ram_one_access: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("palette read and write in the same cycle");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled while the pipeline has room");

  a_lookup_read: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> s1_valid && s1.lookup)
    else $error("palette read without a lookup in stage one");

endmodule
`default_nettype wire
